### rtl/kmc_pkg.sv
`default_nettype none
package kmc_pkg;
    localparam int MaxSamples  = 64;
    localparam int MaxClusters = 16;
    localparam int MaxPasses   = 32;
    localparam int SmpW        = 16;
    localparam int MeanW       = 24;
    localparam int FracW       = 8;
    localparam int DistW       = MeanW + 1;
    localparam int CfgW        = 5;
    localparam int IdxOutW     = 4;
    localparam int CntOutW     = 7;
    localparam logic [CfgW-1:0] CfgReset = 5'd2;

    typedef struct packed {
        logic clear;
        logic acc_en;
        logic wr_en;
    } t_cell_ctl;
endpackage
`default_nettype wire

### rtl/kmc_cell.sv
`default_nettype none
module kmc_cell #(
    parameter int INDEX        = 0,
    parameter int MAX_SAMPLES  = kmc_pkg::MaxSamples,
    parameter int MAX_CLUSTERS = kmc_pkg::MaxClusters,
    localparam int AW = $clog2(MAX_SAMPLES),
    localparam int CW = $clog2(MAX_SAMPLES + 1),
    localparam int SW = kmc_pkg::SmpW + AW,
    localparam int IW = $clog2(MAX_CLUSTERS),
    localparam int KW = $clog2(MAX_CLUSTERS + 1)
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  kmc_pkg::t_cell_ctl              i_ctl,
    input  wire  [KW-1:0]                   i_k,
    input  wire  [IW-1:0]                   i_acc_idx,
    input  wire  signed [kmc_pkg::SmpW-1:0] i_acc_smp,
    input  wire  [IW-1:0]                   i_wr_idx,
    input  wire  signed [kmc_pkg::MeanW-1:0] i_wr_mean,
    input  wire                             i_v,
    input  wire  signed [kmc_pkg::SmpW-1:0] i_smp,
    input  wire  [AW-1:0]                   i_addr,
    input  wire  [IW-1:0]                   i_old,
    input  wire  [IW-1:0]                   i_best,
    input  wire  [kmc_pkg::DistW-1:0]       i_bd,
    output logic                            o_v,
    output logic signed [kmc_pkg::SmpW-1:0] o_smp,
    output logic [AW-1:0]                   o_addr,
    output logic [IW-1:0]                   o_old,
    output logic [IW-1:0]                   o_best,
    output logic [kmc_pkg::DistW-1:0]       o_bd,
    output logic signed [kmc_pkg::MeanW-1:0] o_mean,
    output logic signed [SW-1:0]            o_sum,
    output logic [CW-1:0]                   o_cnt
);
    localparam logic [IW-1:0] MyIdx = IW'(INDEX);

    logic signed [kmc_pkg::MeanW-1:0] r_mean;
    logic signed [SW-1:0]             r_sum;
    logic [CW-1:0]                    r_cnt;
    logic signed [kmc_pkg::DistW-1:0] diff;
    logic [kmc_pkg::DistW-1:0]        gap;
    logic                             active;
    logic                             win;

    always_comb begin
        diff   = kmc_pkg::DistW'(r_mean)
               - {i_smp[kmc_pkg::SmpW-1], i_smp, {kmc_pkg::FracW{1'b0}}};
        gap    = diff[kmc_pkg::DistW-1] ? kmc_pkg::DistW'(-diff) : kmc_pkg::DistW'(diff);
        active = 32'(INDEX) < 32'(i_k);
        win    = active && (gap < i_bd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_v   <= 1'b0;
            r_sum <= '0;
            r_cnt <= '0;
        end else begin
            o_v <= i_v;
            if (i_ctl.clear) begin
                r_sum <= '0;
                r_cnt <= '0;
            end else if (i_ctl.acc_en && i_acc_idx == MyIdx) begin
                r_sum <= r_sum + SW'(i_acc_smp);
                r_cnt <= r_cnt + CW'(1);
            end
        end
        if (i_ctl.wr_en && i_wr_idx == MyIdx) begin
            r_mean <= i_wr_mean;
        end
        o_smp  <= i_smp;
        o_addr <= i_addr;
        o_old  <= i_old;
        o_best <= win ? MyIdx : i_best;
        o_bd   <= win ? gap : i_bd;
    end

    assign o_mean = r_mean;
    assign o_sum  = r_sum;
    assign o_cnt  = r_cnt;
endmodule
`default_nettype wire

### rtl/kmc_div.sv
`default_nettype none
module kmc_div #(
    parameter int DW = 30,
    parameter int VW = 7
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_start,
    input  wire           i_neg,
    input  wire  [DW-1:0] i_num,
    input  wire  [VW-1:0] i_den,
    output logic          o_done,
    output logic [DW-1:0] o_quo
);
    localparam int NW = $clog2(DW + 1);

    logic [DW-1:0] r_num;
    logic [VW-1:0] r_den;
    logic [VW:0]   r_rem;
    logic [NW-1:0] r_n;
    logic          r_busy;
    logic          r_neg;
    logic [VW:0]   rem2;
    logic          ge;

    always_comb begin
        rem2 = {r_rem[VW-1:0], r_num[DW-1]};
        ge   = rem2 >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_n    <= '0;
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_neg  <= i_neg;
            end else if (r_busy) begin
                r_rem <= ge ? rem2 - {1'b0, r_den} : rem2;
                r_num <= {r_num[DW-2:0], ge};
                r_n   <= r_n + NW'(1);
                if (r_n == NW'(DW - 1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_quo = r_neg ? DW'(-r_num) : r_num;
endmodule
`default_nettype wire

### rtl/kmeans_1d_clustering.sv
`default_nettype none
// channel  dir  handshake                tdata / data           tuser / tlast
// s_axis   in   i_s_tvalid/o_s_tready    sample[15:0]           tlast = last
// m_axis   out  o_m_tvalid/i_m_tready    mean,count,overflow    index / last_result
// cfg      in   i_cfg_valid/o_cfg_ready  cluster_count[4:0]     -
// Loading accepts one word per cycle. After the last word the first k samples seed the means,
// then each pass clears the cells, streams every sample through a chain of one cell per
// cluster, updates each non-empty mean with a serial divider and ends with the pass check.
// Reset is synchronous; results wait in an output register while m_axis stalls.
module kmeans_1d_clustering #(
    parameter int MAX_SAMPLES  = kmc_pkg::MaxSamples,
    parameter int MAX_CLUSTERS = kmc_pkg::MaxClusters,
    parameter int MAX_PASSES   = kmc_pkg::MaxPasses
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [15:0] i_s_tdata,   // sample[15:0]
    input  wire         i_s_tlast,
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [31:0] o_m_tdata,   // mean[23:0], member_count[30:24], overflow[31]
    output logic [3:0]  o_m_tuser,   // cluster_index[3:0]
    output logic        o_m_tlast,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [4:0]  i_cfg_data
);
    localparam int AW = $clog2(MAX_SAMPLES);
    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int SW = kmc_pkg::SmpW + AW;
    localparam int IW = $clog2(MAX_CLUSTERS);
    localparam int KW = $clog2(MAX_CLUSTERS + 1);
    localparam int PW = $clog2(MAX_PASSES + 1);
    localparam int DW = SW + kmc_pkg::FracW;
    localparam int RW = $clog2(MAX_CLUSTERS + 5);
    localparam int MW = kmc_pkg::MeanW;
    localparam int QW = kmc_pkg::SmpW;

    typedef enum logic [2:0] {
        S_LOAD, S_SEED, S_CLR, S_ISSUE, S_DRAIN, S_DSTART, S_DWAIT, S_OUT
    } t_state;

    t_state r_state;
    logic [kmc_pkg::CfgW-1:0] r_cfg;
    logic [CW-1:0]  r_cnt;
    logic           r_drop;
    logic [KW-1:0]  r_k;
    logic [PW-1:0]  r_pass;
    logic [CW-1:0]  r_i;
    logic [KW-1:0]  r_j;
    logic [RW-1:0]  r_dr;
    logic           r_changed;

    logic signed [QW-1:0] smem [MAX_SAMPLES];
    logic [IW-1:0]        amem [MAX_SAMPLES];
    logic signed [QW-1:0] r_smp_q;
    logic [IW-1:0]        r_asg_q;
    logic                 r_rd_v;
    logic                 r_rd_pass;
    logic [AW-1:0]        r_rd_a;
    logic                 rd_en;
    logic [AW-1:0]        rd_a;

    logic                 r_acc_v;
    logic [IW-1:0]        r_acc_idx;
    logic signed [QW-1:0] r_acc_smp;

    logic                 r_ov;
    logic [31:0]          r_tdata;
    logic [3:0]           r_tuser;
    logic                 r_tlast;

    logic                 accept;
    logic [CW-1:0]        n_cnt;
    logic [KW-1:0]        n_k;
    logic                 out_load;
    logic [IW-1:0]        jsel;
    kmc_pkg::t_cell_ctl   ctl;
    logic [IW-1:0]        wr_idx;
    logic signed [MW-1:0] wr_mean;
    logic                 div_start;
    logic                 div_done;
    logic [DW-1:0]        div_quo;
    logic [SW-1:0]        sum_mag;

    logic                 ch_v    [MAX_CLUSTERS+1];
    logic signed [QW-1:0] ch_smp  [MAX_CLUSTERS+1];
    logic [AW-1:0]        ch_addr [MAX_CLUSTERS+1];
    logic [IW-1:0]        ch_old  [MAX_CLUSTERS+1];
    logic [IW-1:0]        ch_best [MAX_CLUSTERS+1];
    logic [kmc_pkg::DistW-1:0] ch_bd [MAX_CLUSTERS+1];
    logic signed [MW-1:0] c_mean  [MAX_CLUSTERS];
    logic signed [SW-1:0] c_sum   [MAX_CLUSTERS];
    logic [CW-1:0]        c_cnt   [MAX_CLUSTERS];

    assign accept      = i_s_tvalid && o_s_tready;
    assign o_s_tready  = (r_state == S_LOAD);
    assign o_cfg_ready = 1'b1;
    assign jsel        = r_j[IW-1:0];

    always_comb begin
        int kc;
        n_cnt = (32'(r_cnt) < MAX_SAMPLES) ? r_cnt + CW'(1) : r_cnt;
        kc = (r_cfg == '0) ? 1 : 32'(r_cfg);
        if (kc > MAX_CLUSTERS) kc = MAX_CLUSTERS;
        if (kc > 32'(n_cnt)) kc = 32'(n_cnt);
        n_k = KW'(kc);
    end

    always_comb begin
        rd_en = 1'b0;
        rd_a  = r_i[AW-1:0];
        if (r_state == S_SEED || r_state == S_ISSUE) begin
            rd_en = 1'b1;
        end
    end

    assign sum_mag   = c_sum[jsel][SW-1] ? SW'(-c_sum[jsel]) : SW'(c_sum[jsel]);
    assign div_start = (r_state == S_DSTART) && (r_j != r_k) && (c_cnt[jsel] != '0);
    assign out_load  = (r_state == S_OUT) && (r_j != r_k) && (!r_ov || i_m_tready);

    always_comb begin
        ctl.clear  = (r_state == S_CLR);
        ctl.acc_en = r_acc_v;
        ctl.wr_en  = 1'b0;
        wr_idx     = r_rd_a[IW-1:0];
        wr_mean    = MW'({r_smp_q, {kmc_pkg::FracW{1'b0}}});
        if (r_rd_v && !r_rd_pass) begin
            ctl.wr_en = 1'b1;
            wr_idx    = IW'(r_rd_a);
        end else if (r_state == S_DWAIT && div_done) begin
            ctl.wr_en = 1'b1;
            wr_idx    = jsel;
            wr_mean   = MW'(div_quo);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && 32'(r_cnt) < MAX_SAMPLES) begin
            smem[r_cnt[AW-1:0]] <= i_s_tdata;
        end
        if (rd_en) begin
            r_smp_q <= smem[rd_a];
            r_asg_q <= amem[rd_a];
        end
        if (ch_v[MAX_CLUSTERS]) begin
            amem[ch_addr[MAX_CLUSTERS]] <= ch_best[MAX_CLUSTERS];
        end
        r_rd_a    <= rd_a;
        r_acc_idx <= ch_best[MAX_CLUSTERS];
        r_acc_smp <= ch_smp[MAX_CLUSTERS];
    end

    assign ch_v[0]    = r_rd_v && r_rd_pass;
    assign ch_smp[0]  = r_smp_q;
    assign ch_addr[0] = r_rd_a;
    assign ch_old[0]  = r_asg_q;
    assign ch_best[0] = '0;
    assign ch_bd[0]   = '1;

    for (genvar g = 0; g < MAX_CLUSTERS; g++) begin : g_cell
        kmc_cell #(
            .INDEX(g), .MAX_SAMPLES(MAX_SAMPLES), .MAX_CLUSTERS(MAX_CLUSTERS)
        ) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl), .i_k(r_k),
            .i_acc_idx(r_acc_idx), .i_acc_smp(r_acc_smp),
            .i_wr_idx(wr_idx), .i_wr_mean(wr_mean),
            .i_v(ch_v[g]), .i_smp(ch_smp[g]), .i_addr(ch_addr[g]),
            .i_old(ch_old[g]), .i_best(ch_best[g]), .i_bd(ch_bd[g]),
            .o_v(ch_v[g+1]), .o_smp(ch_smp[g+1]), .o_addr(ch_addr[g+1]),
            .o_old(ch_old[g+1]), .o_best(ch_best[g+1]), .o_bd(ch_bd[g+1]),
            .o_mean(c_mean[g]), .o_sum(c_sum[g]), .o_cnt(c_cnt[g])
        );
    end

    kmc_div #(.DW(DW), .VW(CW)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_neg(c_sum[jsel][SW-1]), .i_num({sum_mag, {kmc_pkg::FracW{1'b0}}}),
        .i_den(c_cnt[jsel]), .o_done(div_done), .o_quo(div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_cfg     <= kmc_pkg::CfgReset;
            r_cnt     <= '0;
            r_drop    <= 1'b0;
            r_k       <= '0;
            r_pass    <= '0;
            r_i       <= '0;
            r_j       <= '0;
            r_dr      <= '0;
            r_changed <= 1'b0;
            r_rd_v    <= 1'b0;
            r_rd_pass <= 1'b0;
            r_acc_v   <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_cfg <= i_cfg_data;
            end
            r_rd_v    <= rd_en;
            r_rd_pass <= (r_state == S_ISSUE);
            r_acc_v   <= ch_v[MAX_CLUSTERS];
            if (ch_v[MAX_CLUSTERS] && ch_old[MAX_CLUSTERS] != ch_best[MAX_CLUSTERS]) begin
                r_changed <= 1'b1;
            end
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (i_m_tready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_LOAD: begin
                    if (accept) begin
                        r_cnt <= n_cnt;
                        if (32'(r_cnt) >= MAX_SAMPLES) begin
                            r_drop <= 1'b1;
                        end
                        if (i_s_tlast) begin
                            r_k     <= n_k;
                            r_pass  <= '0;
                            r_i     <= '0;
                            r_state <= S_SEED;
                        end
                    end
                end
                S_SEED: begin
                    r_i <= r_i + CW'(1);
                    if (32'(r_i) + 1 == 32'(r_k)) begin
                        r_state <= S_CLR;
                    end
                end
                S_CLR: begin
                    r_changed <= (r_pass == '0);
                    r_i       <= '0;
                    r_state   <= S_ISSUE;
                end
                S_ISSUE: begin
                    r_i <= r_i + CW'(1);
                    if (r_i + CW'(1) == r_cnt) begin
                        r_dr    <= '0;
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_dr <= r_dr + RW'(1);
                    if (r_dr == RW'(MAX_CLUSTERS + 3)) begin
                        r_j     <= '0;
                        r_state <= S_DSTART;
                    end
                end
                S_DSTART: begin
                    if (r_j == r_k) begin
                        r_pass <= r_pass + PW'(1);
                        if (!r_changed || 32'(r_pass) + 1 == MAX_PASSES) begin
                            r_j     <= '0;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_CLR;
                        end
                    end else if (c_cnt[jsel] == '0) begin
                        r_j <= r_j + KW'(1);
                    end else begin
                        r_state <= S_DWAIT;
                    end
                end
                S_DWAIT: begin
                    if (div_done) begin
                        r_j     <= r_j + KW'(1);
                        r_state <= S_DSTART;
                    end
                end
                S_OUT: begin
                    if (r_j == r_k) begin
                        r_cnt   <= '0;
                        r_drop  <= 1'b0;
                        r_state <= S_LOAD;
                    end else if (out_load) begin
                        r_j <= r_j + KW'(1);
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_tdata <= {r_drop, kmc_pkg::CntOutW'(c_cnt[jsel]), c_mean[jsel]};
            r_tuser <= kmc_pkg::IdxOutW'(r_j);
            r_tlast <= (r_j + KW'(1) == r_k);
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_tdata;
    assign o_m_tuser  = r_tuser;
    assign o_m_tlast  = r_tlast;
endmodule
`default_nettype wire

### verif/tb_kmeans_1d_clustering.sv
module tb_kmeans_1d_clustering;

    typedef struct {
        logic [15:0] sample;
        logic        last;
    } t_word;

    typedef struct {
        logic [3:0]  index;
        logic [23:0] mean;
        logic [6:0]  count;
        logic        ovf;
        logic        lastr;
    } t_cluster;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [15:0] i_s_tdata;
    logic        i_s_tlast;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [31:0] o_m_tdata;
    logic [3:0]  o_m_tuser;
    logic        o_m_tlast;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [4:0]  i_cfg_data;

    kmeans_1d_clustering dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tlast(i_s_tlast),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata), .o_m_tuser(o_m_tuser), .o_m_tlast(o_m_tlast),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    t_word    pending_words[$];
    t_cluster expected_clusters[$];
    int       errors = 0;
    int       idle_cycles = 0;
    bit       calm = 0;
    bit       hold_off = 0;

    logic signed [15:0] set_samples[kmc_pkg::MaxSamples];
    logic [3:0]         set_assign[kmc_pkg::MaxSamples];
    longint             set_means[kmc_pkg::MaxClusters];
    longint             set_sums[kmc_pkg::MaxClusters];
    int                 set_counts[kmc_pkg::MaxClusters];
    int                 set_loaded = 0;
    bit                 set_dropped = 0;
    int                 k_cfg = kmc_pkg::CfgReset;

    always begin
        i_clk = 1'b1; #10;
        i_clk = 1'b0; #10;
    end

    function automatic longint absl(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic bit cluster_pass(int k, bit first);
        bit     changed;
        int     best;
        longint pos, best_d, d;
        changed = first;
        for (int j = 0; j < k; j++) begin
            set_sums[j] = 0;
            set_counts[j] = 0;
        end
        for (int i = 0; i < set_loaded; i++) begin
            pos = longint'(set_samples[i]) * 256;
            best = 0;
            best_d = absl(set_means[0] - pos);
            for (int j = 1; j < k; j++) begin
                d = absl(set_means[j] - pos);
                if (d < best_d) begin
                    best_d = d;
                    best = j;
                end
            end
            if (!first && set_assign[i] != best) changed = 1;
            set_assign[i] = 4'(best);
            set_sums[best] += set_samples[i];
            set_counts[best]++;
        end
        for (int j = 0; j < k; j++)
            if (set_counts[j] != 0) set_means[j] = (set_sums[j] * 256) / set_counts[j];
        return changed;
    endfunction

    task automatic predict_clusters(t_word w);
        int       k;
        bit       first;
        t_cluster c;
        if (set_loaded < kmc_pkg::MaxSamples) begin
            set_samples[set_loaded] = w.sample;
            set_loaded++;
        end else begin
            set_dropped = 1;
        end
        if (!w.last) return;
        k = k_cfg;
        if (k < 1) k = 1;
        if (k > kmc_pkg::MaxClusters) k = kmc_pkg::MaxClusters;
        if (k > set_loaded) k = set_loaded;
        for (int j = 0; j < k; j++) set_means[j] = longint'(set_samples[j]) * 256;
        first = 1;
        for (int p = 0; p < kmc_pkg::MaxPasses; p++) begin
            if (!cluster_pass(k, first)) begin
                first = 0;
                break;
            end
            first = 0;
        end
        for (int j = 0; j < k; j++) begin
            c.index = 4'(j);
            c.mean = set_means[j][23:0];
            c.count = set_counts[j][6:0];
            c.ovf = set_dropped;
            c.lastr = (j + 1 == k);
            expected_clusters.push_back(c);
        end
        set_loaded = 0;
        set_dropped = 0;
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            i_m_tready <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) predict_clusters('{i_s_tdata, i_s_tlast});
            if (!i_s_tvalid || o_s_tready) begin
                if (pending_words.size() > 0 && !hold_off &&
                    (calm || $urandom_range(99) >= 22)) begin
                    i_s_tdata <= pending_words[0].sample;
                    i_s_tlast <= pending_words[0].last;
                    i_s_tvalid <= 1'b1;
                    void'(pending_words.pop_front());
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
            i_m_tready <= calm || ($urandom_range(99) >= 22);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_cluster e;
        bit       moved;
        if (i_rst_n) begin
            moved = (i_s_tvalid && o_s_tready) || (i_cfg_valid && o_cfg_ready) ||
                    (o_m_tvalid && i_m_tready);
            idle_cycles <= moved ? 0 : idle_cycles + 1;
            if (o_m_tvalid && i_m_tready) begin
                if (expected_clusters.size() == 0) begin
                    $display("%0t unexpected word idx=%0d data=%h", $time, o_m_tuser, o_m_tdata);
                    errors++;
                end else begin
                    e = expected_clusters.pop_front();
                    if (o_m_tuser !== e.index || o_m_tdata[23:0] !== e.mean ||
                        o_m_tdata[30:24] !== e.count || o_m_tdata[31] !== e.ovf ||
                        o_m_tlast !== e.lastr) begin
                        $display("%0t mismatch exp idx=%0d mean=%h cnt=%0d ovf=%b last=%b",
                                 $time, e.index, e.mean, e.count, e.ovf, e.lastr);
                        $display("%0t          act idx=%0d mean=%h cnt=%0d ovf=%b last=%b",
                                 $time, o_m_tuser, o_m_tdata[23:0], o_m_tdata[30:24],
                                 o_m_tdata[31], o_m_tlast);
                        errors++;
                    end
                end
            end
            if (idle_cycles > 200000) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic add_word(logic [15:0] s, logic l);
        pending_words.push_back('{s, l});
    endtask

    task automatic wait_drained();
        while (pending_words.size() > 0 || i_s_tvalid || expected_clusters.size() > 0)
            @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic write_k(logic [4:0] v);
        wait_drained();
        i_cfg_data <= v;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        k_cfg = v;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic add_set(int n, int spread);
        logic [15:0] s;
        int          c;
        for (int i = 0; i < n; i++) begin
            if (spread == 0) s = 16'($urandom);
            else begin
                c = $urandom_range(7) * 8000 - 28000;
                s = 16'(c + $urandom_range(2 * spread) - spread);
            end
            add_word(s, i == n - 1);
        end
    endtask

    initial begin
        int n;
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tlast = 1'b0;
        i_m_tready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset k, extremes, ties
        add_word(16'h8000, 0); add_word(16'h7fff, 0); add_word(16'h0000, 0);
        add_word(16'hffff, 1);
        add_word(16'd10, 0); add_word(16'd20, 0); add_word(16'd15, 1);
        write_k(5'd1);
        add_word(16'h7fff, 0); add_word(16'h7fff, 1);
        write_k(5'd0);
        add_word(16'h1234, 1);
        write_k(5'd31);
        add_word(16'd5, 0); add_word(16'hfffb, 0); add_word(16'd5, 1);
        write_k(5'd16);
        add_set(70, 0);
        wait_drained();

        hold_off = 1;
        repeat (20) @(posedge i_clk);
        hold_off = 0;

        for (int r = 0; r < 14; r++) begin
            write_k(5'($urandom_range(31)));
            calm = (r >= 4 && r <= 7);
            n = ($urandom_range(9) == 0) ? $urandom_range(64, 68) : $urandom_range(1, 24);
            add_set(n, ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 3000));
        end
        write_k(5'd16);
        add_set(20, 500);
        write_k(5'd2);
        add_set(12, 0);
        wait_drained();
        repeat (500) @(posedge i_clk);
        if (errors == 0 && expected_clusters.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
